// ----- design/bhs_pkg.sv -----
package bhs_pkg;

   // default geometry of the table
   localparam int BUCKETS_DEF = 1024;
   localparam int SLOTS_DEF   = 4;

   // key width and stored entry layout: {valid, key}
   localparam int KEY_W   = 31;
   localparam int ENTRY_W = KEY_W + 1;

   // operation codes; the unused code behaves as a search
   localparam logic [1:0] KIND_SEARCH = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   // request payload
   typedef struct packed {
      logic [1:0]       kind;
      logic [KEY_W-1:0] key;
   } req_type;

   // response payload
   typedef struct packed {
      logic hit;
      logic changed;
      logic full_res;
   } rsp_type;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_READ,
      ST_UPDATE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic clear_en;
      logic mul1_en;
      logic mul2_en;
      logic read_en;
      logic update_en;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_done;
   } ctl_stat_type;

endpackage

// ----- design/bhs_ctrl.sv -----
module bhs_ctrl #(
   parameter int BUCKETS = bhs_pkg::BUCKETS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bhs_pkg::ctl_stat_type stat,
   output bhs_pkg::ctl_cmd_type  cmd
);
   import bhs_pkg::*;

   // a power-of-two bucket count needs no reciprocal reduction
   localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // a new request may enter while the previous row is written back
   assign busy   = !((state_ff == ST_IDLE) || (state_ff == ST_UPDATE));
   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_UPDATE: begin
            if (accept) begin
               state_in = POW2 ? ST_READ : ST_MUL1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd      = '0;
      cmd.load = accept;
      case (state_ff)
         ST_CLEAR:  cmd.clear_en  = 1'b1;
         ST_MUL1:   cmd.mul1_en   = 1'b1;
         ST_MUL2:   cmd.mul2_en   = 1'b1;
         ST_READ:   cmd.read_en   = 1'b1;
         ST_UPDATE: cmd.update_en = 1'b1;
         default:   cmd.load      = accept;
      endcase
   end

endmodule

// ----- design/bhs_datapath.sv -----
module bhs_datapath #(
   parameter int BUCKETS = bhs_pkg::BUCKETS_DEF,
   parameter int SLOTS   = bhs_pkg::SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bhs_pkg::req_type      req_data,
   input  bhs_pkg::ctl_cmd_type  cmd,
   output bhs_pkg::ctl_stat_type stat,
   output logic                  rsp_strobe,
   output bhs_pkg::rsp_type      rsp_data
);
   import bhs_pkg::*;

   localparam int IDX_W = $clog2(BUCKETS);
   localparam int ROW_W = SLOTS * ENTRY_W;
   localparam bit POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

   // key mod BUCKETS by reciprocal: q = (key * RECIP) >> SHIFT is exact or one low
   localparam int          SHIFT      = KEY_W + IDX_W;
   localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(BUCKETS);
   localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
   localparam logic [KEY_W-1:0] BUCKETS_K = KEY_W'(BUCKETS);

   // request registers
   logic [1:0]       kind_ff;
   logic [KEY_W-1:0] key_ff;

   // reduction pipeline
   logic [62:0]      prod1_full;
   logic [KEY_W-1:0] quot_ff;
   logic [61:0]      prod2_full;
   logic [KEY_W-1:0] prod2_ff;
   logic [KEY_W-1:0] rem_raw;
   logic [KEY_W-1:0] rem_adj;
   logic [IDX_W-1:0] bucket_idx;

   // table memory and its ports
   logic [ROW_W-1:0] mem [BUCKETS];
   logic [ROW_W-1:0] rd_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] clr_cnt_ff;
   logic [IDX_W-1:0] clr_cnt_in;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ROW_W-1:0] wr_row;

   // slot compare
   logic [SLOTS-1:0] match_vec;
   logic [SLOTS-1:0] free_vec;
   logic [SLOTS-1:0] match_low;
   logic [SLOTS-1:0] free_low;
   logic [ROW_W-1:0] new_row;
   logic             is_add;
   logic             is_del;
   rsp_type          rsp_in;
   rsp_type          rsp_ff;
   logic             strobe_ff;

   // capture request on transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_data.kind;
         key_ff  <= req_data.key;
      end
   end

   // quotient estimate, then quotient times bucket count
   assign prod1_full = 63'(key_ff) * 63'(RECIP);
   assign prod2_full = 62'(quot_ff) * 62'(BUCKETS_K);

   always_ff @(posedge clock) begin
      if (cmd.mul1_en) begin
         quot_ff <= KEY_W'(prod1_full >> SHIFT);
      end
      if (cmd.mul2_en) begin
         prod2_ff <= prod2_full[KEY_W-1:0];
      end
   end

   // remainder lies below twice the bucket count: one correction step
   assign rem_raw    = key_ff - prod2_ff;
   assign rem_adj    = (rem_raw >= BUCKETS_K) ? (rem_raw - BUCKETS_K) : rem_raw;
   assign bucket_idx = POW2 ? key_ff[IDX_W-1:0] : rem_adj[IDX_W-1:0];

   // clearing pass counter
   assign clr_cnt_in      = clr_cnt_ff + IDX_W'(1);
   assign stat.clear_done = (clr_cnt_ff == IDX_W'(BUCKETS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // memory write port: clearing pass or row write-back
   assign wr_en   = cmd.clear_en || cmd.update_en;
   assign wr_addr = cmd.clear_en ? clr_cnt_ff : idx_ff;
   assign wr_row  = cmd.clear_en ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // memory read port
   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_ff  <= mem[bucket_idx];
         idx_ff <= bucket_idx;
      end
   end

   // per-slot compare and replacement
   assign is_add = (kind_ff == KIND_ADD);
   assign is_del = (kind_ff == KIND_DELETE);

   for (genvar s = 0; s < SLOTS; s++) begin : g_slot
      logic [ENTRY_W-1:0] entry;
      assign entry        = rd_ff[s*ENTRY_W +: ENTRY_W];
      assign match_vec[s] = entry[ENTRY_W-1] && (entry[KEY_W-1:0] == key_ff);
      assign free_vec[s]  = !entry[ENTRY_W-1];

      assign new_row[s*ENTRY_W +: ENTRY_W] =
         (is_add && free_low[s])  ? {1'b1, key_ff} :
         (is_del && match_low[s]) ? {ENTRY_W{1'b0}} : entry;
   end

   // lowest-numbered matching and free slot
   assign match_low = match_vec & (~match_vec + SLOTS'(1));
   assign free_low  = free_vec & (~free_vec + SLOTS'(1));

   // response
   always_comb begin
      rsp_in.hit      = |match_vec;
      rsp_in.changed  = (is_add && (|free_vec)) || (is_del && (|match_vec));
      rsp_in.full_res = is_add && !(|free_vec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.update_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- design/bucketed_hash_set_core.sv -----
// Bucketed hash set: search, add or delete one 31-bit key per request.
// Request channel: drive req_data and raise start; the request transfers at
// the rising edge where start is high and busy is low.
// Response channel: rsp_data is valid for the single cycle in which
// rsp_strobe is high; there is no back-pressure, so the receiver must take
// it in that cycle.
// The key picks bucket key mod BUCKETS; each bucket is one memory row of
// SLOTS entries, read once and written back once per request.
// From its transfer, a request passes the states READ and UPDATE and then the
// response register when BUCKETS is a power of two; otherwise two extra multiply
// stages (MUL1, MUL2) for the modulo come first. busy stays high from the
// transfer until the request reaches its UPDATE state.
// A new request can transfer in the write-back cycle of the previous one.
// Reset: a clearing pass writes every row to empty, one row per cycle, once
// reset is released; busy stays high meanwhile.
module bucketed_hash_set_core #(
   parameter int BUCKETS = bhs_pkg::BUCKETS_DEF,
   parameter int SLOTS   = bhs_pkg::SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bhs_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bhs_pkg::rsp_type rsp_data
);
   import bhs_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // sequencing
   bhs_ctrl #(
      .BUCKETS (BUCKETS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // hashing, table storage and slot compare
   bhs_datapath #(
      .BUCKETS (BUCKETS),
      .SLOTS   (SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- design/bhs_checker.sv -----
module bhs_checker #(
   parameter int BUCKETS = bhs_pkg::BUCKETS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam int LAT  = POW2 ? 3 : 5;

   logic xfer;
   assign xfer = start && !busy;

   // every transfer is followed by its response
   a_xfer_to_rsp: assert property (@(posedge clock) disable iff (reset)
      xfer |-> ##LAT rsp_strobe)
      else $error("response missing after request transfer");

   // every response traces back to a transfer
   a_rsp_from_xfer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(xfer, LAT))
      else $error("response without matching request transfer");

   // responses are never back to back
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("responses in consecutive cycles");

   // clearing pass holds off requests right after reset
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("not busy right after reset");

endmodule

bind bucketed_hash_set_core bhs_checker #(
   .BUCKETS (BUCKETS)
) u_bhs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
